[design/km2d_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// km2d_pkg
// Shared widths, codes, types and states of the 2-D k-means iteration block.
// ----------------------------------------------------------------------------
package km2d_pkg;

   localparam int NUM_CLUSTERS  = 4;
   localparam int COORD_BITS    = 16;
   localparam int INDEX_BITS    = 10;
   localparam int PRIOR_DEPTH   = 1 << INDEX_BITS;
   localparam int COUNT_BITS    = 11;
   localparam int CLUSTER_BITS  = 5;
   localparam int CL_BITS       = (NUM_CLUSTERS > 1) ? $clog2(NUM_CLUSTERS) : 1;
   localparam int SUM_BITS      = COORD_BITS + COUNT_BITS;
   localparam int SQ_BITS       = 2 * COORD_BITS;
   localparam int DIST_BITS     = SQ_BITS + 1;
   localparam int STEP_BITS     = CL_BITS + 2;
   localparam int DIV_CNT_BITS  = $clog2(SUM_BITS + 1);

   localparam int REQ_FIELD_BITS = INDEX_BITS + 2 * COORD_BITS;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = CLUSTER_BITS + 2 * COORD_BITS + COUNT_BITS + 1;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   localparam logic FUNC_LOAD     = 1'b0;
   localparam logic FUNC_SAMPLE   = 1'b1;
   localparam logic KIND_SAMPLE   = 1'b0;
   localparam logic KIND_CENTROID = 1'b1;

   typedef struct packed {
      logic [REQ_DATA_BITS-REQ_FIELD_BITS-1:0] pad;
      logic [COORD_BITS-1:0]                   y;
      logic [COORD_BITS-1:0]                   x;
      logic [INDEX_BITS-1:0]                   index;
   } req_data_type;

   typedef struct packed {
      logic [RSP_DATA_BITS-RSP_FIELD_BITS-1:0] pad;
      logic                                    converged;
      logic [COUNT_BITS-1:0]                   member_count;
      logic [COORD_BITS-1:0]                   new_y;
      logic [COORD_BITS-1:0]                   new_x;
      logic [CLUSTER_BITS-1:0]                 cluster;
   } rsp_data_type;

   typedef struct packed {
      logic               valid;
      logic [CL_BITS-1:0] cluster;
   } prior_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIST,
      ST_UPDATE,
      ST_RPT_X,
      ST_WAIT_X,
      ST_WAIT_Y,
      ST_EMIT
   } state_type;

endpackage
`default_nettype wire

[design/km2d_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// km2d_div
// Restoring divider, one quotient bit per cycle, for the centroid means.
// ----------------------------------------------------------------------------
module km2d_div (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic [km2d_pkg::SUM_BITS-1:0]       dividend,
   input  wire logic [km2d_pkg::COUNT_BITS-1:0]     divisor,
   output km2d_pkg::div_status_type                 status,
   output logic [km2d_pkg::COORD_BITS-1:0]          quotient
);

   logic                                  busy_ff;
   logic                                  done_ff;
   logic [km2d_pkg::DIV_CNT_BITS-1:0]     cnt_ff;
   logic [km2d_pkg::SUM_BITS-1:0]         quo_ff;
   logic [km2d_pkg::COUNT_BITS-1:0]       rem_ff;
   logic [km2d_pkg::COUNT_BITS-1:0]       div_ff;

   logic [km2d_pkg::COUNT_BITS:0]         trial;
   logic [km2d_pkg::COUNT_BITS:0]         diff;
   logic                                  fits;
   logic [km2d_pkg::COUNT_BITS-1:0]       rem_in;

   always_comb begin
      trial  = {rem_ff, quo_ff[km2d_pkg::SUM_BITS-1]};
      diff   = trial - {1'b0, div_ff};
      fits   = trial >= {1'b0, div_ff};
      rem_in = fits ? diff[km2d_pkg::COUNT_BITS-1:0] : trial[km2d_pkg::COUNT_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == km2d_pkg::DIV_CNT_BITS'(km2d_pkg::SUM_BITS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[km2d_pkg::SUM_BITS-2:0], fits};
         rem_ff <= rem_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff[km2d_pkg::COORD_BITS-1:0];

endmodule
`default_nettype wire

[design/kmeans_2d_lloyd_iteration.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kmeans_2d_lloyd_iteration
// One Lloyd k-means pass over 2-D Q0.16 points with a shared distance unit.
// ----------------------------------------------------------------------------
// usage
//   req channel: tuser = func (0 load centroid, 1 assign sample), tlast marks
//   the last sample of the pass, tdata = index, x, y
//   rsp channel: tuser = kind (0 assignment, 1 centroid report), tlast marks
//   the last result of a request, tdata = cluster, new_x, new_y, member_count,
//   converged
//   a load request gives no result
//   a sample request gives its result from the update state, and the next request
//   is taken once the block is back in the idle state: one squarer visits the x
//   and y distance of every centroid in turn, then come a pipeline register,
//   the update state and the idle state
//   the last sample then adds, for each non-empty cluster, two runs of the
//   one-bit-per-cycle divider that form x and then y of its mean
//   after reset the prior-assignment memory is swept, one entry per cycle, over
//   all PRIOR_DEPTH entries, with req_tready low
//   results sit in an output register; while the receiver stalls the block
//   carries on until it holds a new result and then waits with req_tready low
// ----------------------------------------------------------------------------
module kmeans_2d_lloyd_iteration (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   input  wire logic [km2d_pkg::REQ_DATA_BITS-1:0]    req_tdata,  // index, x, y
   input  wire logic                                  req_tuser,  // func
   input  wire logic                                  req_tlast,  // last
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic [km2d_pkg::RSP_DATA_BITS-1:0]         rsp_tdata,  // cluster, new_x, new_y,
                                                                  // member_count, converged
   output logic                                       rsp_tuser,  // kind
   output logic                                       rsp_tlast   // end_of_run
);

   localparam int K = km2d_pkg::NUM_CLUSTERS;
   localparam int CB = km2d_pkg::CL_BITS;
   localparam int CW = km2d_pkg::COORD_BITS;
   localparam int NB = km2d_pkg::COUNT_BITS;
   localparam int SB = km2d_pkg::SUM_BITS;

   km2d_pkg::state_type state_ff, state_in;
   km2d_pkg::req_data_type req_data;

   // model state
   logic [CW-1:0] cx_ff [K];
   logic [CW-1:0] cy_ff [K];
   logic [SB-1:0] sx_ff [K];
   logic [SB-1:0] sy_ff [K];
   logic [NB-1:0] cnt_ff [K];
   logic          unch_ff;

   // sequencer
   logic [km2d_pkg::INDEX_BITS-1:0] clr_ff;
   logic [km2d_pkg::STEP_BITS-1:0]  step_ff;
   logic [CB-1:0]                   sel_ff;
   logic                            sq_vld_ff;

   // payload
   logic [km2d_pkg::INDEX_BITS-1:0] idx_ff;
   logic [CW-1:0]                   px_ff, py_ff;
   logic                            last_ff;
   logic [km2d_pkg::SQ_BITS-1:0]    sq_ff;
   logic                            sq_y_ff;
   logic [CB-1:0]                   sq_cl_ff;
   logic [km2d_pkg::SQ_BITS-1:0]    part_ff;
   logic [km2d_pkg::DIST_BITS-1:0]  best_ff;
   logic [CB-1:0]                   best_idx_ff;
   logic [CW-1:0]                   qx_ff, qy_ff;

   km2d_pkg::prior_type prior_mem [km2d_pkg::PRIOR_DEPTH];
   km2d_pkg::prior_type prior_rd_ff;
   km2d_pkg::prior_type mem_wd;
   logic [km2d_pkg::INDEX_BITS-1:0] mem_wa;
   logic                            mem_we;

   logic                       rsp_tvalid_ff;
   km2d_pkg::rsp_data_type     rsp_data_ff;
   logic                       rsp_tuser_ff;
   logic                       rsp_tlast_ff;

   // strobes
   logic out_free, accept, load_fire, sample_fire, clr_run, clr_done;
   logic dist_done, upd_fire, emit_fire, div_start, empty_sel, last_sel;

   // distance unit
   logic [CB-1:0]                  a_cl;
   logic                           a_y, a_vld;
   logic [CW-1:0]                  a_c, a_p, a_d;
   logic [km2d_pkg::SQ_BITS-1:0]   a_sq;
   logic [km2d_pkg::DIST_BITS-1:0] b_total;

   // update
   logic [NB-1:0]  u_cur, u_cnt;
   logic           u_sat, u_changed, u_conv;

   // divider
   logic [SB-1:0]                  div_dividend;
   km2d_pkg::div_status_type       div_status;
   logic [CW-1:0]                  div_q;

   assign req_data = km2d_pkg::req_data_type'(req_tdata);
   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign accept   = req_tvalid && req_tready;
   assign clr_done = clr_ff == km2d_pkg::INDEX_BITS'(km2d_pkg::PRIOR_DEPTH - 1);
   assign dist_done = step_ff == km2d_pkg::STEP_BITS'(2 * K);
   assign empty_sel = cnt_ff[sel_ff] == '0;
   assign last_sel  = sel_ff == CB'(K - 1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         km2d_pkg::ST_CLEAR:  if (clr_done) state_in = km2d_pkg::ST_IDLE;
         km2d_pkg::ST_IDLE:   if (req_tvalid && req_tuser == km2d_pkg::FUNC_SAMPLE)
                                 state_in = km2d_pkg::ST_DIST;
         km2d_pkg::ST_DIST:   if (dist_done) state_in = km2d_pkg::ST_UPDATE;
         km2d_pkg::ST_UPDATE: if (out_free)
                                 state_in = last_ff ? km2d_pkg::ST_RPT_X : km2d_pkg::ST_IDLE;
         km2d_pkg::ST_RPT_X:  state_in = empty_sel ? km2d_pkg::ST_EMIT : km2d_pkg::ST_WAIT_X;
         km2d_pkg::ST_WAIT_X: if (div_status.done) state_in = km2d_pkg::ST_WAIT_Y;
         km2d_pkg::ST_WAIT_Y: if (div_status.done) state_in = km2d_pkg::ST_EMIT;
         km2d_pkg::ST_EMIT:   if (out_free)
                                 state_in = last_sel ? km2d_pkg::ST_IDLE : km2d_pkg::ST_RPT_X;
         default:             state_in = km2d_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready = 1'b0;
      clr_run    = 1'b0;
      upd_fire   = 1'b0;
      emit_fire  = 1'b0;
      div_start  = 1'b0;
      unique case (state_ff)
         km2d_pkg::ST_CLEAR:  clr_run = 1'b1;
         km2d_pkg::ST_IDLE:   req_tready = 1'b1;
         km2d_pkg::ST_UPDATE: upd_fire = out_free;
         km2d_pkg::ST_RPT_X:  div_start = !empty_sel;
         km2d_pkg::ST_WAIT_X: div_start = div_status.done;
         km2d_pkg::ST_EMIT:   emit_fire = out_free;
         default: ;
      endcase
   end

   assign load_fire   = accept && req_tuser == km2d_pkg::FUNC_LOAD
                        && req_data.index < km2d_pkg::INDEX_BITS'(K);
   assign sample_fire = accept && req_tuser == km2d_pkg::FUNC_SAMPLE;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= km2d_pkg::ST_CLEAR;
      else       state_ff <= state_in;
   end

   // shared distance unit: one squared coordinate difference per cycle
   always_comb begin
      a_cl    = step_ff[CB:1];
      a_y     = step_ff[0];
      a_vld   = (state_ff == km2d_pkg::ST_DIST) && (step_ff < km2d_pkg::STEP_BITS'(2 * K));
      a_c     = a_y ? cy_ff[a_cl] : cx_ff[a_cl];
      a_p     = a_y ? py_ff : px_ff;
      a_d     = (a_c > a_p) ? a_c - a_p : a_p - a_c;
      a_sq    = km2d_pkg::SQ_BITS'(a_d) * km2d_pkg::SQ_BITS'(a_d);
      b_total = km2d_pkg::DIST_BITS'(part_ff) + km2d_pkg::DIST_BITS'(sq_ff);
   end

   // update of the winning cluster
   always_comb begin
      u_cur     = cnt_ff[best_idx_ff];
      u_sat     = u_cur == km2d_pkg::COUNT_MAX;
      u_cnt     = u_sat ? u_cur : u_cur + 1'b1;
      u_changed = !prior_rd_ff.valid || prior_rd_ff.cluster != best_idx_ff;
      u_conv    = unch_ff && !u_changed;
   end

   assign div_dividend = ((state_ff == km2d_pkg::ST_WAIT_X) ? sy_ff[sel_ff] : sx_ff[sel_ff])
                         + SB'(cnt_ff[sel_ff] >> 1);

   km2d_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (cnt_ff[sel_ff]),
      .status   (div_status),
      .quotient (div_q)
   );

   // control and model state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < K; i++) begin
            cx_ff[i]  <= '0;
            cy_ff[i]  <= '0;
            sx_ff[i]  <= '0;
            sy_ff[i]  <= '0;
            cnt_ff[i] <= '0;
         end
         unch_ff   <= 1'b1;
         clr_ff    <= '0;
         step_ff   <= '0;
         sel_ff    <= '0;
         sq_vld_ff <= 1'b0;
      end else begin
         if (clr_run) clr_ff <= clr_ff + 1'b1;
         if (load_fire) begin
            cx_ff[req_data.index[CB-1:0]] <= req_data.x;
            cy_ff[req_data.index[CB-1:0]] <= req_data.y;
         end
         if (sample_fire) step_ff <= '0;
         else if (state_ff == km2d_pkg::ST_DIST) step_ff <= step_ff + 1'b1;
         sq_vld_ff <= a_vld;
         if (upd_fire) begin
            cnt_ff[best_idx_ff] <= u_cnt;
            if (!u_sat) begin
               sx_ff[best_idx_ff] <= sx_ff[best_idx_ff] + SB'(px_ff);
               sy_ff[best_idx_ff] <= sy_ff[best_idx_ff] + SB'(py_ff);
            end
            unch_ff <= u_conv;
            sel_ff  <= '0;
         end
         if (emit_fire) begin
            cx_ff[sel_ff]  <= qx_ff;
            cy_ff[sel_ff]  <= qy_ff;
            sx_ff[sel_ff]  <= '0;
            sy_ff[sel_ff]  <= '0;
            cnt_ff[sel_ff] <= '0;
            sel_ff         <= sel_ff + 1'b1;
            if (last_sel) unch_ff <= 1'b1;
         end
      end
   end

   // datapath payload
   always_ff @(posedge clock) begin
      if (sample_fire) begin
         idx_ff  <= req_data.index;
         px_ff   <= req_data.x;
         py_ff   <= req_data.y;
         last_ff <= req_tlast;
      end
      if (a_vld) begin
         sq_ff    <= a_sq;
         sq_y_ff  <= a_y;
         sq_cl_ff <= a_cl;
      end
      if (sq_vld_ff) begin
         if (!sq_y_ff) begin
            part_ff <= sq_ff;
         end else if (sq_cl_ff == '0 || b_total < best_ff) begin
            best_ff     <= b_total;
            best_idx_ff <= sq_cl_ff;
         end
      end
      if (state_ff == km2d_pkg::ST_RPT_X && empty_sel) begin
         qx_ff <= cx_ff[sel_ff];
         qy_ff <= cy_ff[sel_ff];
      end
      if (state_ff == km2d_pkg::ST_WAIT_X && div_status.done) qx_ff <= div_q;
      if (state_ff == km2d_pkg::ST_WAIT_Y && div_status.done) qy_ff <= div_q;
   end

   // prior-assignment memory
   always_comb begin
      mem_we = clr_run || upd_fire;
      mem_wa = clr_run ? clr_ff : idx_ff;
      mem_wd.valid   = !clr_run;
      mem_wd.cluster = clr_run ? '0 : best_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) prior_mem[mem_wa] <= mem_wd;
      prior_rd_ff <= prior_mem[idx_ff];
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (upd_fire || emit_fire) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (upd_fire) begin
         rsp_data_ff.pad          <= '0;
         rsp_data_ff.converged    <= u_conv;
         rsp_data_ff.member_count <= u_cnt;
         rsp_data_ff.new_y        <= '0;
         rsp_data_ff.new_x        <= '0;
         rsp_data_ff.cluster      <= km2d_pkg::CLUSTER_BITS'(best_idx_ff);
         rsp_tuser_ff             <= km2d_pkg::KIND_SAMPLE;
         rsp_tlast_ff             <= !last_ff;
      end else if (emit_fire) begin
         rsp_data_ff.pad          <= '0;
         rsp_data_ff.converged    <= unch_ff;
         rsp_data_ff.member_count <= cnt_ff[sel_ff];
         rsp_data_ff.new_y        <= qy_ff;
         rsp_data_ff.new_x        <= qx_ff;
         rsp_data_ff.cluster      <= km2d_pkg::CLUSTER_BITS'(sel_ff);
         rsp_tuser_ff             <= km2d_pkg::KIND_CENTROID;
         rsp_tlast_ff             <= last_sel;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   // checks
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("divider started while busy");

   a_sweep_silent: assert property (@(posedge clock) disable iff (reset)
      state_ff == km2d_pkg::ST_CLEAR |-> !rsp_tvalid && !req_tready)
      else $error("activity during memory sweep");

   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      sample_fire |=> !req_tready)
      else $error("ready right after a sample request");

endmodule
`default_nettype wire

[tb/sv/tb_kmeans_2d_lloyd_iteration.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kmeans_2d_lloyd_iteration
// Checks the 2-D Lloyd k-means block against a cycle-free predictor. The
// directed requests cover corner points, ignored loads, an empty cluster, a
// converged pass and a distance tie. Random passes replay sample sets so that
// the centroids settle.
// Both stream sides idle at random; every response is compared field by field.
// ----------------------------------------------------------------------------
module tb_kmeans_2d_lloyd_iteration;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 300;
   localparam int PRINT_CAP      = 40;
   localparam int TARGET_ITEMS   = 160;
   localparam int COORD_MAX      = (1 << km2d_pkg::COORD_BITS) - 1;

   typedef struct {
      logic                            func;
      logic [km2d_pkg::INDEX_BITS-1:0] index;
      logic [km2d_pkg::COORD_BITS-1:0] x;
      logic [km2d_pkg::COORD_BITS-1:0] y;
      logic                            last;
      bit                              hold;
   } point_request_type;

   typedef struct {
      logic                              kind;
      logic [km2d_pkg::CLUSTER_BITS-1:0] cluster;
      logic [km2d_pkg::COORD_BITS-1:0]   new_x;
      logic [km2d_pkg::COORD_BITS-1:0]   new_y;
      logic [km2d_pkg::COUNT_BITS-1:0]   member_count;
      logic                              converged;
      logic                              end_of_run;
   } lloyd_result_type;

   logic                               clock      = 1'b0;
   logic                               reset      = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [km2d_pkg::REQ_DATA_BITS-1:0] req_tdata  = '0;   // index, x, y
   logic                               req_tuser  = 1'b0; // func
   logic                               req_tlast  = 1'b0; // last
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [km2d_pkg::RSP_DATA_BITS-1:0] rsp_tdata;  // cluster, new_x, new_y, member_count,
                                                   // converged
   logic                               rsp_tuser;  // kind
   logic                               rsp_tlast;  // end_of_run

   point_request_type pending_requests [$];
   lloyd_result_type  lloyd_results_due [$];
   point_request_type req_active;

   // predictor state
   logic [km2d_pkg::COORD_BITS-1:0] cent_x [km2d_pkg::NUM_CLUSTERS];
   logic [km2d_pkg::COORD_BITS-1:0] cent_y [km2d_pkg::NUM_CLUSTERS];
   int unsigned                     sum_x [km2d_pkg::NUM_CLUSTERS];
   int unsigned                     sum_y [km2d_pkg::NUM_CLUSTERS];
   int unsigned                     members [km2d_pkg::NUM_CLUSTERS];
   bit                              prior_seen [km2d_pkg::PRIOR_DEPTH];
   int unsigned                     prior_cl [km2d_pkg::PRIOR_DEPTH];
   bit                              pass_stable;

   int results_predicted = 0;
   int results_checked   = 0;
   int error_count       = 0;
   int idle_cycles       = 0;
   int req_gap           = 0;
   int req_quiet         = 0;
   int rsp_stall         = 0;
   int rsp_quiet         = 0;
   int loads_sent        = 0;
   int samples_sent      = 0;
   int passes_done       = 0;
   int stable_passes     = 0;
   int empty_reports     = 0;

   kmeans_2d_lloyd_iteration dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   function automatic int rand_coord();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return COORD_MAX;
         default: return $urandom_range(0, COORD_MAX);
      endcase
   endfunction

   function automatic int jitter(input int base);
      int v;
      v = base + int'($urandom_range(0, 4095)) - 2048;
      if (v < 0) v = 0;
      if (v > COORD_MAX) v = COORD_MAX;
      return v;
   endfunction

   task automatic add_request(input logic func, input int index, input int x, input int y,
                              input logic last, input bit hold);
      point_request_type rq;
      rq.func  = func;
      rq.index = index[km2d_pkg::INDEX_BITS-1:0];
      rq.x     = x[km2d_pkg::COORD_BITS-1:0];
      rq.y     = y[km2d_pkg::COORD_BITS-1:0];
      rq.last  = last;
      rq.hold  = hold;
      pending_requests.push_back(rq);
   endtask

   function automatic void push_result(input logic kind, input int cl,
                                       input logic [km2d_pkg::COORD_BITS-1:0] nx,
                                       input logic [km2d_pkg::COORD_BITS-1:0] ny,
                                       input int cnt, input bit conv, input bit eor);
      lloyd_result_type res;
      res.kind         = kind;
      res.cluster      = cl[km2d_pkg::CLUSTER_BITS-1:0];
      res.new_x        = nx;
      res.new_y        = ny;
      res.member_count = cnt[km2d_pkg::COUNT_BITS-1:0];
      res.converged    = conv;
      res.end_of_run   = eor;
      lloyd_results_due.push_back(res);
      results_predicted++;
   endfunction

   function automatic void run_lloyd_step(input point_request_type rq);
      longint unsigned dx, dy, span, best_span;
      int best, slot;
      slot = int'(rq.index);
      best = 0;
      best_span = 0;
      if (rq.func == km2d_pkg::FUNC_LOAD) begin
         if (slot < km2d_pkg::NUM_CLUSTERS) begin
            cent_x[slot] = rq.x;
            cent_y[slot] = rq.y;
         end
         return;
      end
      for (int k = 0; k < km2d_pkg::NUM_CLUSTERS; k++) begin
         dx = (cent_x[k] > rq.x) ? cent_x[k] - rq.x : rq.x - cent_x[k];
         dy = (cent_y[k] > rq.y) ? cent_y[k] - rq.y : rq.y - cent_y[k];
         span = dx * dx + dy * dy;
         // strict compare keeps the lowest index on a tie
         if (k == 0 || span < best_span) begin
            best = k;
            best_span = span;
         end
      end
      if (members[best] < km2d_pkg::COUNT_MAX) begin
         members[best]++;
         sum_x[best] += rq.x;
         sum_y[best] += rq.y;
      end
      if (!prior_seen[slot] || prior_cl[slot] != best) pass_stable = 1'b0;
      prior_seen[slot] = 1'b1;
      prior_cl[slot] = best;
      push_result(km2d_pkg::KIND_SAMPLE, best, '0, '0, members[best], pass_stable, !rq.last);
      if (rq.last) begin
         passes_done++;
         if (pass_stable) stable_passes++;
         for (int k = 0; k < km2d_pkg::NUM_CLUSTERS; k++) begin
            if (members[k] != 0) begin
               cent_x[k] = (sum_x[k] + members[k] / 2) / members[k];
               cent_y[k] = (sum_y[k] + members[k] / 2) / members[k];
            end else begin
               empty_reports++;
            end
            push_result(km2d_pkg::KIND_CENTROID, k, cent_x[k], cent_y[k], members[k],
                        pass_stable, k == km2d_pkg::NUM_CLUSTERS - 1);
            sum_x[k] = 0;
            sum_y[k] = 0;
            members[k] = 0;
         end
         pass_stable = 1'b1;
      end
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("response %0d %s got %0h expected %0h",
                                   results_checked, name, got, want));
   endtask

   // request driver
   always @(posedge clock) begin
      km2d_pkg::req_data_type req_packed;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            run_lloyd_step(req_active);
            if (req_active.func == km2d_pkg::FUNC_LOAD) loads_sent++;
            else samples_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_requests.size() != 0 &&
                         !(pending_requests[0].hold && results_predicted != results_checked)) begin
               req_active = pending_requests.pop_front();
               req_packed = '0;
               req_packed.index = req_active.index;
               req_packed.x = req_active.x;
               req_packed.y = req_active.y;
               req_tdata  <= req_packed;
               req_tuser  <= req_active.func;
               req_tlast  <= req_active.last;
               req_tvalid <= 1'b1;
               if (req_quiet > 0) req_quiet--;
               else if ($urandom_range(0, 24) == 0) req_quiet = $urandom_range(10, 40);
               req_gap = (req_quiet > 0) ? 0 : pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      km2d_pkg::rsp_data_type got;
      lloyd_result_type       want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = km2d_pkg::rsp_data_type'(rsp_tdata);
            if (lloyd_results_due.size() == 0) begin
               report_mismatch($sformatf("response %0d arrived with nothing expected",
                                         results_checked));
            end else begin
               want = lloyd_results_due.pop_front();
               check_field("kind", rsp_tuser, want.kind);
               check_field("cluster", got.cluster, want.cluster);
               check_field("new_x", got.new_x, want.new_x);
               check_field("new_y", got.new_y, want.new_y);
               check_field("member_count", got.member_count, want.member_count);
               check_field("converged", got.converged, want.converged);
               check_field("end_of_run", rsp_tlast, want.end_of_run);
            end
            results_checked <= results_checked + 1;
            if (rsp_quiet > 0) rsp_quiet--;
            else if ($urandom_range(0, 24) == 0) rsp_quiet = $urandom_range(10, 40);
            rsp_stall = (rsp_quiet > 0) ? 0 : pick_gap();
         end else if (!rsp_tvalid && rsp_stall == 0 && $urandom_range(0, 15) == 0) begin
            rsp_stall = pick_gap();
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin : stimulus
      int nset, npass, nload, slot, ax, ay;
      int set_idx [16];
      int set_x [16];
      int set_y [16];
      bit first;

      for (int k = 0; k < km2d_pkg::NUM_CLUSTERS; k++) begin
         cent_x[k] = '0;
         cent_y[k] = '0;
         sum_x[k] = 0;
         sum_y[k] = 0;
         members[k] = 0;
      end
      for (int i = 0; i < km2d_pkg::PRIOR_DEPTH; i++) begin
         prior_seen[i] = 1'b0;
         prior_cl[i] = 0;
      end
      pass_stable = 1'b1;

      // corner centroids, out of range loads ignored
      add_request(km2d_pkg::FUNC_LOAD, 0, 0, 0, 1'b0, 1'b0);
      add_request(km2d_pkg::FUNC_LOAD, 1, COORD_MAX, COORD_MAX, 1'b1, 1'b0);
      add_request(km2d_pkg::FUNC_LOAD, 2, 0, COORD_MAX, 1'b0, 1'b0);
      add_request(km2d_pkg::FUNC_LOAD, 3, COORD_MAX, 0, 1'b0, 1'b0);
      add_request(km2d_pkg::FUNC_LOAD, km2d_pkg::NUM_CLUSTERS, 'h8000, 'h8000, 1'b0, 1'b0);
      add_request(km2d_pkg::FUNC_LOAD, km2d_pkg::PRIOR_DEPTH - 1, 'h1234, 'h4321, 1'b0, 1'b0);
      // cluster 3 stays empty; the second pass repeats the first and converges
      for (int p = 0; p < 2; p++) begin
         add_request(km2d_pkg::FUNC_SAMPLE, 0, 0, 0, 1'b0, p == 1);
         add_request(km2d_pkg::FUNC_SAMPLE, km2d_pkg::PRIOR_DEPTH - 1, COORD_MAX, COORD_MAX,
                     1'b0, 1'b0);
         add_request(km2d_pkg::FUNC_SAMPLE, 512, 0, COORD_MAX, 1'b0, 1'b0);
         add_request(km2d_pkg::FUNC_SAMPLE, 1, 0, 0, 1'b0, 1'b0);
         add_request(km2d_pkg::FUNC_SAMPLE, 2, COORD_MAX, COORD_MAX, 1'b1, 1'b0);
      end
      // twin centroids: tie goes to the lower index
      add_request(km2d_pkg::FUNC_LOAD, 3, 0, COORD_MAX, 1'b0, 1'b0);
      add_request(km2d_pkg::FUNC_SAMPLE, 512, 0, COORD_MAX, 1'b1, 1'b0);
      add_request(km2d_pkg::FUNC_SAMPLE, 768, 'h8000, 'h7FFF, 1'b1, 1'b0);

      first = 1'b1;
      while (pending_requests.size() < TARGET_ITEMS - 12) begin
         nload = $urandom_range(0, 4);
         for (int i = 0; i < nload; i++) begin
            slot = ($urandom_range(0, 7) == 0)
                   ? $urandom_range(km2d_pkg::NUM_CLUSTERS, km2d_pkg::PRIOR_DEPTH - 1)
                   : $urandom_range(0, km2d_pkg::NUM_CLUSTERS - 1);
            add_request(km2d_pkg::FUNC_LOAD, slot, rand_coord(), rand_coord(),
                        $urandom_range(0, 1), 1'b0);
         end
         nset = $urandom_range(2, 16);
         ax = rand_coord();
         ay = rand_coord();
         for (int i = 0; i < nset; i++) begin
            set_idx[i] = ($urandom_range(0, 3) == 0)
                         ? $urandom_range(0, km2d_pkg::PRIOR_DEPTH - 1)
                         : $urandom_range(0, 31);
            if ($urandom_range(0, 2) == 0) begin
               ax = rand_coord();
               ay = rand_coord();
            end
            set_x[i] = ($urandom_range(0, 4) == 0) ? rand_coord() : jitter(ax);
            set_y[i] = ($urandom_range(0, 4) == 0) ? rand_coord() : jitter(ay);
         end
         // replay the set so the centroids settle
         npass = $urandom_range(1, 4);
         for (int p = 0; p < npass; p++) begin
            for (int i = 0; i < nset; i++) begin
               add_request(km2d_pkg::FUNC_SAMPLE, set_idx[i], set_x[i], set_y[i],
                           i == nset - 1, i == 0 && (first || $urandom_range(0, 3) == 0));
               first = 1'b0;
            end
         end
         // stray samples, some closing a pass early
         if ($urandom_range(0, 5) == 0) begin
            for (int i = 0; i < $urandom_range(1, 3); i++) begin
               add_request(km2d_pkg::FUNC_SAMPLE, $urandom_range(0, km2d_pkg::PRIOR_DEPTH - 1),
                           rand_coord(), rand_coord(), $urandom_range(0, 1), 1'b0);
            end
         end
      end

      while (pending_requests.size() != 0 || req_tvalid || lloyd_results_due.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("ran %0d centroid loads and %0d samples in %0d passes, %0d of them converged",
               loads_sent, samples_sent, passes_done, stable_passes);
      $display("checked %0d responses, %0d of them reports of an empty cluster",
               results_checked, empty_reports);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
